@@ rtl/core/aqam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqam_pkg
// Shared types, thresholds and register codes of the air quality alarm monitor.
// ----------------------------------------------------------------------------
package aqam_pkg;

  localparam int TIME_W  = 48;
  localparam int AVG_W   = 16;
  localparam int GRADE_W = 3;
  localparam int DUTY_W  = 8;
  localparam int BOUND_W = 11;
  localparam int HOLD_W  = 26;
  localparam int DUR_W   = 20;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 4;

  localparam logic [AVG_W-1:0]   AVG_MAX     = '1;
  localparam logic [GRADE_W-1:0] NO_DANGER   = 3'd7;
  localparam logic [GRADE_W-1:0] ALERT_GRADE = 3'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ALERT_EN = 2'd0;
  localparam reg_idx_t REG_HOLDOFF  = 2'd1;
  localparam reg_idx_t REG_BUZZ_DUR = 2'd2;

  localparam logic [HOLD_W-1:0] HOLDOFF_RST  = 26'd5000000;
  localparam logic [DUR_W-1:0]  BUZZ_DUR_RST = 20'd50000;

  // grade thresholds in tenths, lowest bound in entry 0
  typedef logic [3:0][BOUND_W-1:0] bounds_t;
  localparam bounds_t CO_BOUNDS = {11'd155, 11'd125, 11'd95, 11'd45};
  localparam bounds_t PM_BOUNDS = {11'd1504, 11'd554, 11'd354, 11'd120};

  typedef struct packed {
    logic              enable;
    logic [HOLD_W-1:0] holdoff_us;
    logic [DUR_W-1:0]  buzz_dur_us;
  } cfg_t;

  typedef struct packed {
    logic               done;
    logic [AVG_W-1:0]   avg;
    logic [GRADE_W-1:0] grade;
  } lane_out_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic               worst_source;
    logic               raise_alert;
    logic               buzzer_on;
    logic [DUTY_W-1:0]  led_duty;
    logic [GRADE_W-1:0] danger_grade;
    logic [GRADE_W-1:0] pm_grade;
    logic [GRADE_W-1:0] co_grade;
    logic [AVG_W-1:0]   avg_pm;
    logic [AVG_W-1:0]   avg_co;
  } out_word_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic [GRADE_W-1:0] g);
    logic [DUTY_W-1:0] d;
    case (g)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd7;
      3'd2:    d = 8'd15;
      3'd3:    d = 8'd31;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/aqam_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqam_lane
// One sensor channel: sample ring, serial sum, bit-serial divide and grading.
// ----------------------------------------------------------------------------
module aqam_lane #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 16,
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int FILL_W     = $clog2(WINDOW + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [SLOT_W-1:0]     wr_slot,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic                  rep_start,
  input  logic [FILL_W-1:0]     fill,
  input  aqam_pkg::bounds_t     bounds,
  input  logic                  take,
  output aqam_pkg::lane_out_t   res
);
  import aqam_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + FILL_W;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int CMP_W0 = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;
  localparam int CMP_W  = (CMP_W0 > AVG_W) ? CMP_W0 : AVG_W + 1;

  typedef enum logic [4:0] {
    L_IDLE  = 5'b00001,
    L_SUM   = 5'b00010,
    L_DIV   = 5'b00100,
    L_GRADE = 5'b01000,
    L_DONE  = 5'b10000
  } lane_state_t;

  lane_state_t          state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] ring_r [WINDOW];
  logic [SLOT_W-1:0]    idx_r;
  logic [FILL_W-1:0]    fill_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     quo_r;
  logic [FILL_W-1:0]    rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [AVG_W-1:0]     avg_r;
  logic [GRADE_W-1:0]   grade_r;

  logic                 last_idx;
  logic [FILL_W:0]      trial;
  logic [FILL_W:0]      diff;
  logic                 fits;
  logic [FILL_W-1:0]    rem_nxt;
  logic [CMP_W-1:0]     q_ext;
  logic [GRADE_W-1:0]   grade_nxt;
  logic [AVG_W-1:0]     avg_nxt;

  always_comb begin
    last_idx = (FILL_W'(idx_r) == fill_r - FILL_W'(1));
    trial    = {rem_r, quo_r[SUM_W-1]};
    diff     = trial - {1'b0, fill_r};
    fits     = (trial >= {1'b0, fill_r});
    rem_nxt  = fits ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
    q_ext    = CMP_W'(quo_r);
    avg_nxt  = (q_ext > CMP_W'(AVG_MAX)) ? AVG_MAX : q_ext[AVG_W-1:0];
    grade_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      grade_nxt = grade_nxt + GRADE_W'(q_ext >= CMP_W'(bounds[i]));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE:  if (rep_start) state_nxt = L_SUM;
      L_SUM:   if (last_idx) state_nxt = L_DIV;
      L_DIV:   if (cnt_r == '0) state_nxt = L_GRADE;
      L_GRADE: state_nxt = L_DONE;
      L_DONE:  if (take) state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_r[wr_slot] <= wr_data;
    end
    case (state_r)
      L_IDLE: begin
        if (rep_start) begin
          fill_r <= fill;
          idx_r  <= '0;
          sum_r  <= '0;
        end
      end
      L_SUM: begin
        sum_r <= sum_r + SUM_W'(ring_r[idx_r]);
        idx_r <= idx_r + SLOT_W'(1);
        if (last_idx) begin
          quo_r <= sum_r + SUM_W'(ring_r[idx_r]);
          rem_r <= '0;
          cnt_r <= CNT_W'(SUM_W - 1);
        end
      end
      L_DIV: begin
        quo_r <= {quo_r[SUM_W-2:0], fits};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      L_GRADE: begin
        avg_r   <= avg_nxt;
        grade_r <= grade_nxt;
      end
      default: ;
    endcase
  end

  assign res.done  = (state_r == L_DONE);
  assign res.avg   = avg_r;
  assign res.grade = grade_r;

endmodule

@@ rtl/core/aqam_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqam_merge
// Combines both lanes: danger level, LED duty, buzzer and alert state, result word.
// ----------------------------------------------------------------------------
module aqam_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [aqam_pkg::TIME_W-1:0]   now_us,
  input  aqam_pkg::cfg_t                cfg,
  input  aqam_pkg::lane_out_t           co,
  input  aqam_pkg::lane_out_t           pm,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output aqam_pkg::out_word_t           out_word
);
  import aqam_pkg::*;

  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  end_cand_r;
  logic               holdoff_ok_r;
  logic               exp_old_r;
  logic               exp_new_r;
  logic [GRADE_W-1:0] prev_danger_r, prev_danger_nxt;
  logic [TIME_W-1:0]  last_alert_r, last_alert_nxt;
  logic               buzz_act_r, buzz_act_nxt;
  logic [TIME_W-1:0]  buzz_end_r, buzz_end_nxt;
  logic               out_valid_r;
  out_word_t          out_r, out_nxt;

  logic [GRADE_W-1:0] danger;
  logic               hot;
  logic               starting;
  logic               fire;
  logic               act_mid;
  logic               expired;

  always_comb begin
    take     = co.done & pm.done & (~out_valid_r | out_ready);
    danger   = (co.grade > pm.grade) ? co.grade : pm.grade;
    hot      = cfg.enable && (danger >= ALERT_GRADE);
    starting = hot && !buzz_act_r;
    fire     = hot && (prev_danger_r < ALERT_GRADE || prev_danger_r == NO_DANGER ||
                       holdoff_ok_r);
    act_mid  = cfg.enable ? (buzz_act_r | hot) : 1'b0;
    expired  = starting ? exp_new_r : exp_old_r;

    buzz_act_nxt    = act_mid && !expired;
    buzz_end_nxt    = starting ? end_cand_r : buzz_end_r;
    last_alert_nxt  = fire ? now_r : last_alert_r;
    prev_danger_nxt = cfg.enable ? danger : NO_DANGER;

    out_nxt              = '0;
    out_nxt.avg_co       = co.avg;
    out_nxt.avg_pm       = pm.avg;
    out_nxt.co_grade     = co.grade;
    out_nxt.pm_grade     = pm.grade;
    out_nxt.danger_grade = danger;
    out_nxt.led_duty     = cfg.enable ? duty_of(danger) : '0;
    out_nxt.buzzer_on    = buzz_act_nxt;
    out_nxt.raise_alert  = fire;
    out_nxt.worst_source = (co.grade > pm.grade) ? 1'b0 : 1'b1;
  end

  // time math for the report is prepared while the lanes work
  always_ff @(posedge clk) begin
    if (start) begin
      now_r        <= now_us;
      end_cand_r   <= now_us + TIME_W'(cfg.buzz_dur_us);
      holdoff_ok_r <= (now_us - last_alert_r) >= TIME_W'(cfg.holdoff_us);
    end
    exp_old_r <= (now_r >= buzz_end_r);
    exp_new_r <= (now_r >= end_cand_r);
    if (take) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_danger_r <= NO_DANGER;
      last_alert_r  <= '0;
      buzz_act_r    <= 1'b0;
      buzz_end_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (take) begin
        prev_danger_r <= prev_danger_nxt;
        last_alert_r  <= last_alert_nxt;
        buzz_act_r    <= buzz_act_nxt;
        buzz_end_r    <= buzz_end_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

@@ rtl/core/air_quality_alarm_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// air_quality_alarm_monitor
// Two-channel CO / PM2.5 window averaging, grading and alarm control.
// ----------------------------------------------------------------------------
// A sample word (tuser 0) is taken and stored in both rings. A
// report word (tuser 1) runs the CO and PM2.5 lanes side by side: each lane
// sums its ring one entry per cycle, then divides by the fill count one
// quotient bit per cycle, then grades; the result word is loaded, and the
// input is freed for the next word, at the same clock edge. The input is
// held off while a report is in the lanes. A report before the first sample
// gives no result. A result waiting at the output does not hold off the input,
// but a later report that finishes while it waits stays in the lanes, holding
// off the input, until the waiting result is taken.
module air_quality_alarm_monitor #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [79:0]                   in_tdata,   // co_sample, pm_sample, now_us
  input  logic                          in_tuser,   // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // avg_co, avg_pm, co_grade, pm_grade, danger_grade, led_duty, buzzer_on,
  // raise_alert, worst_source, zero fill
  output logic [55:0]                   out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [aqam_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [aqam_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [aqam_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import aqam_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);

  cfg_t                cfg_r;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [FILL_W-1:0]   fill_count_r, fill_count_nxt;
  logic                busy_r;

  logic                accept;
  logic                sample_acc;
  logic                rep_acc;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic                take;
  lane_out_t           co_res;
  lane_out_t           pm_res;
  out_word_t           out_word;

  assign in_tready  = ~busy_r;
  assign accept     = in_tvalid & in_tready;
  assign sample_acc = accept & (in_tuser == OP_SAMPLE);
  assign rep_acc    = accept & (in_tuser == OP_REPORT) & (fill_count_r != '0);

  assign slot_nxt       = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
  assign fill_count_nxt = (fill_count_r == FILL_W'(WINDOW)) ? fill_count_r
                                                            : fill_count_r + FILL_W'(1);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_ALERT_EN: cfg_prdata = CFG_DW'(cfg_r.enable);
      REG_HOLDOFF:  cfg_prdata = CFG_DW'(cfg_r.holdoff_us);
      REG_BUZZ_DUR: cfg_prdata = CFG_DW'(cfg_r.buzz_dur_us);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b0;
      cfg_r.holdoff_us  <= HOLDOFF_RST;
      cfg_r.buzz_dur_us <= BUZZ_DUR_RST;
      slot_r            <= '0;
      fill_count_r      <= '0;
      busy_r            <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ALERT_EN: cfg_r.enable      <= cfg_pwdata[0];
          REG_HOLDOFF:  cfg_r.holdoff_us  <= cfg_pwdata[HOLD_W-1:0];
          REG_BUZZ_DUR: cfg_r.buzz_dur_us <= cfg_pwdata[DUR_W-1:0];
          default: ;
        endcase
      end
      if (sample_acc) begin
        slot_r       <= slot_nxt;
        fill_count_r <= fill_count_nxt;
      end
      if (rep_acc) begin
        busy_r <= 1'b1;
      end else if (take) begin
        busy_r <= 1'b0;
      end
    end
  end

  aqam_lane #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_co_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (sample_acc),
    .wr_slot   (slot_r),
    .wr_data   (SAMPLE_BITS'(in_tdata[15:0])),
    .rep_start (rep_acc),
    .fill      (fill_count_r),
    .bounds    (CO_BOUNDS),
    .take      (take),
    .res       (co_res)
  );

  aqam_lane #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pm_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (sample_acc),
    .wr_slot   (slot_r),
    .wr_data   (SAMPLE_BITS'(in_tdata[31:16])),
    .rep_start (rep_acc),
    .fill      (fill_count_r),
    .bounds    (PM_BOUNDS),
    .take      (take),
    .res       (pm_res)
  );

  aqam_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rep_acc),
    .now_us    (in_tdata[79:32]),
    .cfg       (cfg_r),
    .co        (co_res),
    .pm        (pm_res),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = out_word;

`ifndef ASSERT_OFF
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    co_res.done == pm_res.done)
    else $error("lanes out of step");

  a_ring_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= FILL_W'(WINDOW) && slot_r <= SLOT_W'(WINDOW - 1))
    else $error("ring pointer out of range");

  a_report_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    rep_acc |=> busy_r && !in_tready)
    else $error("report accepted without holding input");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $fell(busy_r))
    else $error("result loaded outside a report");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the air quality alarm monitor. A clocked driver
// sends sample and report words from a queue in random bursts. A clocked
// monitor stalls the result channel on its own pattern and checks every
// result word field by field against an in-bench alarm predictor. The
// alarm registers are rewritten between phases over the APB port, while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import aqam_pkg::*;

  localparam int RING_DEPTH = 5;
  localparam int SETTLE_CYC = 60;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic              op;
    logic [15:0]       co;
    logic [15:0]       pm;
    logic [TIME_W-1:0] now_us;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [79:0]       in_tdata = '0;   // co_sample, pm_sample, now_us
  logic              in_tuser = 1'b0; // opcode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;       // avg_co, avg_pm, grades, duty, flags, zero fill
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  air_quality_alarm_monitor u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  word_t     word_q[$];
  out_word_t report_q[$];
  int        err_cnt = 0;

  // register shadow
  logic              alert_en = 1'b0;
  logic [HOLD_W-1:0] holdoff_us = HOLDOFF_RST;
  logic [DUR_W-1:0]  buzz_dur_us = BUZZ_DUR_RST;

  // alarm state
  logic [15:0]        co_ring [RING_DEPTH];
  logic [15:0]        pm_ring [RING_DEPTH];
  int unsigned        wr_slot = 0;
  int unsigned        fill = 0;
  logic [GRADE_W-1:0] prev_dng = NO_DANGER;
  logic [TIME_W-1:0]  last_alert_us = '0;
  logic               buzz_on = 1'b0;
  logic [TIME_W-1:0]  buzz_end_us = '0;

  logic [TIME_W-1:0]  t_now = '0;

  function automatic logic [GRADE_W-1:0] level_of(input int unsigned avg,
      input int unsigned b0, input int unsigned b1, input int unsigned b2,
      input int unsigned b3);
    logic [GRADE_W-1:0] lvl;
    lvl = '0;
    if (avg >= b0) lvl++;
    if (avg >= b1) lvl++;
    if (avg >= b2) lvl++;
    if (avg >= b3) lvl++;
    return lvl;
  endfunction

  function automatic logic [DUTY_W-1:0] led_duty_for(input logic [GRADE_W-1:0] lvl);
    logic [DUTY_W-1:0] d;
    case (lvl)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd7;
      3'd2:    d = 8'd15;
      3'd3:    d = 8'd31;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

  task automatic update_alarm_model(input word_t w);
    int unsigned        co_sum, pm_sum, co_avg, pm_avg;
    logic [GRADE_W-1:0] co_g, pm_g, dng;
    logic [TIME_W-1:0]  since_alert;
    out_word_t          r;
    co_sum = 0;
    pm_sum = 0;
    r = '0;
    if (w.op == OP_SAMPLE) begin
      co_ring[wr_slot] = w.co;
      pm_ring[wr_slot] = w.pm;
      wr_slot = (wr_slot == RING_DEPTH - 1) ? 0 : wr_slot + 1;
      if (fill < RING_DEPTH) fill++;
    end else if (fill != 0) begin
      for (int i = 0; i < fill; i++) begin
        co_sum += 32'(co_ring[i]);
        pm_sum += 32'(pm_ring[i]);
      end
      co_avg = co_sum / fill;
      pm_avg = pm_sum / fill;
      co_g = level_of(co_avg, 45, 95, 125, 155);
      pm_g = level_of(pm_avg, 120, 354, 554, 1504);
      dng = (co_g > pm_g) ? co_g : pm_g;
      r.raise_alert = 1'b0;
      r.led_duty = '0;
      if (alert_en) begin
        r.led_duty = led_duty_for(dng);
        if (dng >= ALERT_GRADE) begin
          if (!buzz_on) begin
            buzz_on = 1'b1;
            buzz_end_us = w.now_us + {{(TIME_W-DUR_W){1'b0}}, buzz_dur_us};
          end
          since_alert = w.now_us - last_alert_us;
          if (prev_dng < ALERT_GRADE || prev_dng == NO_DANGER ||
              since_alert >= {{(TIME_W-HOLD_W){1'b0}}, holdoff_us}) begin
            r.raise_alert = 1'b1;
            last_alert_us = w.now_us;
          end
        end
        prev_dng = dng;
      end else begin
        buzz_on = 1'b0;
        prev_dng = NO_DANGER;
      end
      if (buzz_on && w.now_us >= buzz_end_us) buzz_on = 1'b0;
      r.avg_co = co_avg[15:0];
      r.avg_pm = pm_avg[15:0];
      r.co_grade = co_g;
      r.pm_grade = pm_g;
      r.danger_grade = dng;
      r.buzzer_on = buzz_on;
      r.worst_source = (co_g > pm_g) ? 1'b0 : 1'b1;
      report_q.push_back(r);
    end
  endtask

  // driver: bursts of words with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drv
    logic fire;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        update_alarm_model(word_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (in_tvalid && !fire) begin
        // hold the current word
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {word_q[0].now_us, word_q[0].pm, word_q[0].co};
        in_tuser <= word_q[0].op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // monitor with its own stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  int cyc = 0;

  always @(posedge clk) begin : mon
    out_word_t got;
    out_word_t want;
    cyc++;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        want = report_q.pop_front();
        check_field("avg_co", 64'(want.avg_co), 64'(got.avg_co));
        check_field("avg_pm", 64'(want.avg_pm), 64'(got.avg_pm));
        check_field("co_grade", 64'(want.co_grade), 64'(got.co_grade));
        check_field("pm_grade", 64'(want.pm_grade), 64'(got.pm_grade));
        check_field("danger_grade", 64'(want.danger_grade), 64'(got.danger_grade));
        check_field("led_duty", 64'(want.led_duty), 64'(got.led_duty));
        check_field("buzzer_on", 64'(want.buzzer_on), 64'(got.buzzer_on));
        check_field("raise_alert", 64'(want.raise_alert), 64'(got.raise_alert));
        check_field("worst_source", 64'(want.worst_source), 64'(got.worst_source));
        check_field("zero fill", 64'(want.pad), 64'(got.pad));
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= ((cyc % 7) < 2);
    endcase
  end

  int idle_cyc = 0;

  always @(posedge clk) begin : wdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cyc);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ALERT_EN: alert_en = val[0];
      REG_HOLDOFF:  holdoff_us = val[HOLD_W-1:0];
      REG_BUZZ_DUR: buzz_dur_us = val[DUR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_alarm_regs(input logic en, input logic [HOLD_W-1:0] hold,
      input logic [DUR_W-1:0] dur);
    write_reg(REG_ALERT_EN, {31'd0, en});
    write_reg(REG_HOLDOFF, {6'd0, hold});
    write_reg(REG_BUZZ_DUR, {12'd0, dur});
  endtask

  task automatic queue_word(input logic op, input logic [15:0] co, input logic [15:0] pm,
      input logic [TIME_W-1:0] now_us);
    word_t w;
    w.op = op;
    w.co = co;
    w.pm = pm;
    w.now_us = now_us;
    word_q.push_back(w);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (word_q.size() != 0 || in_tvalid || report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [15:0] sample_for(input int regime, input bit pm_chan);
    logic [15:0] v;
    case (regime)
      0:       v = 16'(pm_chan ? $urandom_range(0, 130) : $urandom_range(0, 50));
      1:       v = 16'(pm_chan ? $urandom_range(100, 600) : $urandom_range(40, 140));
      2:       v = 16'(pm_chan ? $urandom_range(500, 3000) : $urandom_range(120, 400));
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic random_words(input int n);
    int unsigned pick;
    int          co_reg, pm_reg;
    word_t       w;
    co_reg = 0;
    pm_reg = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) begin
        co_reg = $urandom_range(0, 3);
        pm_reg = $urandom_range(0, 3);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        t_now[47:32] = 16'($urandom);
        t_now[31:0] = $urandom;
      end else if (pick < 6) begin
        t_now = 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 100000));
      end else if (pick < 14) begin
        t_now = t_now + TIME_W'($urandom_range(0, 1 << 27));
      end else if (pick < 17) begin
        t_now = t_now - TIME_W'($urandom_range(0, 5000));
      end else begin
        t_now = t_now + TIME_W'($urandom_range(0, 20000));
      end
      w.op = ($urandom_range(0, 99) < 60) ? OP_SAMPLE : OP_REPORT;
      if ($urandom_range(0, 19) == 0) begin
        w.co = 16'($urandom);
        w.pm = 16'($urandom);
      end else begin
        w.co = sample_for(co_reg, 1'b0);
        w.pm = sample_for(pm_reg, 1'b1);
      end
      w.now_us = t_now;
      word_q.push_back(w);
    end
  endtask

  initial begin : stim
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // alert mode off: empty window, field extremes, window wrap, exact bounds
    queue_word(OP_REPORT, 16'd0, 16'd0, 48'd0);
    queue_word(OP_SAMPLE, 16'd0, 16'd0, 48'd10);
    queue_word(OP_REPORT, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    queue_word(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 48'd20);
    queue_word(OP_REPORT, 16'd0, 16'd0, 48'd30);
    queue_word(OP_SAMPLE, 16'd44, 16'd119, 48'd40);
    queue_word(OP_SAMPLE, 16'd45, 16'd120, 48'd50);
    queue_word(OP_REPORT, 16'd0, 16'd0, 48'd60);
    for (int i = 0; i < 5; i++) queue_word(OP_SAMPLE, 16'd95, 16'd354, 48'd70 + TIME_W'(i));
    queue_word(OP_REPORT, 16'd0, 16'd0, 48'd80);
    wait_idle();

    // alert mode on: rising danger, buzzer expiry, hold-off, time wrap
    set_alarm_regs(1'b1, 26'd1000, 20'd500);
    t_now = 48'd1_000_000;
    queue_word(OP_REPORT, 16'd0, 16'd0, t_now);
    for (int i = 0; i < 5; i++) queue_word(OP_SAMPLE, 16'd200, 16'd2000, t_now);
    queue_word(OP_REPORT, 16'd0, 16'd0, t_now);
    queue_word(OP_REPORT, 16'd0, 16'd0, t_now + 48'd10);
    queue_word(OP_REPORT, 16'd0, 16'd0, t_now + 48'd600);
    queue_word(OP_REPORT, 16'd0, 16'd0, t_now + 48'd1100);
    queue_word(OP_REPORT, 16'd0, 16'd0, 48'hFFFF_FFFF_FF00);
    queue_word(OP_REPORT, 16'd0, 16'd0, 48'hFFFF_FFFF_FFFF - 48'd100);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_alarm_regs(1'b1, '0, '0);
        1: set_alarm_regs(1'b1, '1, '1);
        2: set_alarm_regs(1'b0, HOLDOFF_RST, BUZZ_DUR_RST);
        3: set_alarm_regs(1'b1, HOLD_W'($urandom_range(0, 200000)),
                          DUR_W'($urandom_range(0, 60000)));
        4: set_alarm_regs(1'b1, HOLD_W'($urandom_range(1000, 50000)),
                          DUR_W'($urandom_range(0, 20000)));
        default: set_alarm_regs(1'b1, HOLDOFF_RST, BUZZ_DUR_RST);
      endcase
      random_words(230);
      wait_idle();
    end

    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (report_q.size() != 0)
        $display("%0t: %0d result words never arrived", $time, report_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
